FILE: rtl/core/ffbp_pkg.sv
// ============================================================================
// ffbp_pkg
// shared widths, constants and the item token carried along the bin cell row
// ============================================================================
`default_nettype none

package ffbp_pkg;

    localparam int SIZE_W       = 17;        // item size and bin fill, unsigned Q1.16
    localparam int BIN_INDEX_W  = 9;         // bin_index field
    localparam int BINS_USED_W  = 10;        // bins_used field
    localparam int MAX_BINS_DEF = 512;

    localparam logic [SIZE_W-1:0] CAP_RESET = 17'h10000;  // 1.0

    // one item as it walks from cell to cell
    typedef struct packed {
        logic              valid;
        logic              first;    // empty every bin it passes
        logic              placed;   // already taken by an earlier cell
        logic [SIZE_W-1:0] size;
    } tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/ffbp_cell.sv
// ============================================================================
// ffbp_cell
// one bin: holds its fill and open flag, tries to take the passing item
// ============================================================================
`default_nettype none

module ffbp_cell #(
    parameter int IDX_W    = 9,
    parameter int CNT_W    = 10,
    parameter int CELL_IDX = 0
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [ffbp_pkg::SIZE_W-1:0] cap,
    input  wire ffbp_pkg::tok_t            tok_in,
    input  wire logic [IDX_W-1:0]          chosen_in,
    input  wire logic [CNT_W-1:0]          used_in,
    output ffbp_pkg::tok_t                 tok_out,
    output logic [IDX_W-1:0]               chosen_out,
    output logic [CNT_W-1:0]               used_out
);
    import ffbp_pkg::*;

    logic [SIZE_W-1:0] fill_reg;
    logic [SIZE_W-1:0] fill_next;
    logic              open_reg;
    logic              open_next;
    logic              open_eff;
    logic [SIZE_W:0]   sum;
    logic              fits;
    logic              place_here;
    logic              open_here;
    logic              try_item;

    tok_t              tok_reg;
    tok_t              tok_next;
    logic [IDX_W-1:0]  chosen_reg;
    logic [IDX_W-1:0]  chosen_next;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;

    always_comb
    begin
        // a first item empties this bin before it looks at it
        open_eff   = open_reg & ~(tok_in.valid & tok_in.first);
        sum        = {1'b0, fill_reg} + {1'b0, tok_in.size};
        fits       = (sum <= {1'b0, cap});
        try_item   = tok_in.valid & ~tok_in.placed;
        place_here = try_item & open_eff & fits;
        open_here  = try_item & ~open_eff & (tok_in.size <= cap);

        open_next  = open_eff | open_here;
        if (place_here)
        begin
            fill_next = sum[SIZE_W-1:0];
        end
        else if (open_here)
        begin
            fill_next = tok_in.size;
        end
        else
        begin
            fill_next = fill_reg;
        end

        tok_next        = tok_in;
        tok_next.placed = tok_in.placed | place_here | open_here;
        chosen_next     = (place_here | open_here) ? IDX_W'(CELL_IDX) : chosen_in;
        used_next       = used_in + {{(CNT_W-1){1'b0}}, open_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else if (advance)
        begin
            open_reg <= open_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fill_reg   <= fill_next;
            chosen_reg <= chosen_next;
            used_reg   <= used_next;
        end
    end

    assign tok_out    = tok_reg;
    assign chosen_out = chosen_reg;
    assign used_out   = used_reg;

endmodule

`default_nettype wire

FILE: rtl/core/first_fit_bin_packer_top.sv
// ============================================================================
// first_fit_bin_packer_top
// online first-fit bin packer built as a row of bin cells
// ============================================================================
// Each accepted item walks down a row of MAX_BINS bin cells, one cell per
// cycle while the row advances; cell k holds bin k. The item lands in the first
// open bin where it fits, or opens the first closed bin, and counts open bins
// on its way. Items follow one per cycle while no result is held, so the
// sustained rate is one item per clock. The last cell is the output register:
// while a result is held by m_axis_tready low the whole row stands still and
// s_axis_tready is low. An item with first_item set empties each bin as it
// passes, so later items see a fresh set. The user must write capacity on the
// cfg channel only while the row holds no items; the block does not enforce it.
`default_nettype none

module first_fit_bin_packer_top #(
    parameter int MAX_BINS = ffbp_pkg::MAX_BINS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [16:0] item_size, rest zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] first_item
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [8:0] bin_index, [18:9] bins_used
    output logic [0:0]       m_axis_tuser,   // [0] no_room
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [ffbp_pkg::SIZE_W-1:0] cfg_data   // bin_capacity
);
    import ffbp_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [SIZE_W-1:0] cap_reg;
    logic              advance;

    tok_t              tok      [MAX_BINS+1];
    logic [IDX_W-1:0]  chosen   [MAX_BINS+1];
    logic [CNT_W-1:0]  used     [MAX_BINS+1];

    logic [IDX_W+BIN_INDEX_W-1:0] idx_ext;
    logic [CNT_W+BINS_USED_W-1:0] used_ext;
    logic [BIN_INDEX_W-1:0]       bin_index;
    logic [BINS_USED_W-1:0]       bins_used;
    tok_t                         last_tok;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // the whole row moves unless a finished result is held
    assign advance       = ~last_tok.valid | m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        tok[0].valid  = s_axis_tvalid;
        tok[0].first  = s_axis_tuser[0];
        tok[0].placed = 1'b0;
        tok[0].size   = s_axis_tdata[SIZE_W-1:0];
        chosen[0]     = '0;
        used[0]       = '0;
    end

    for (genvar k = 0; k < MAX_BINS; k++)
    begin : g_cell
        ffbp_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cap        (cap_reg),
            .tok_in     (tok[k]),
            .chosen_in  (chosen[k]),
            .used_in    (used[k]),
            .tok_out    (tok[k+1]),
            .chosen_out (chosen[k+1]),
            .used_out   (used[k+1])
        );
    end

    assign last_tok = tok[MAX_BINS];

    // dropped items report bin 0; counts are cut to the field widths
    assign idx_ext   = {{BIN_INDEX_W{1'b0}},
                        (last_tok.placed ? chosen[MAX_BINS] : {IDX_W{1'b0}})};
    assign used_ext  = {{BINS_USED_W{1'b0}}, used[MAX_BINS]};
    assign bin_index = idx_ext[BIN_INDEX_W-1:0];
    assign bins_used = used_ext[BINS_USED_W-1:0];

    assign m_axis_tvalid = last_tok.valid;
    assign m_axis_tdata  = {5'b0, bins_used, bin_index};
    assign m_axis_tuser  = ~last_tok.placed;

    // a dropped item always reports bin 0
    a_drop_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (bin_index == '0))
        else $error("dropped item reports a nonzero bin");

    // a placed item lies inside the set of open bins
    a_placed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_tok.valid && last_tok.placed) |->
            ((IDX_W+CNT_W)'(chosen[MAX_BINS]) < (IDX_W+CNT_W)'(used[MAX_BINS])))
        else $error("placed bin is not below the open bin count");

    // the row holds still while a result waits
    a_hold_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while held");

endmodule

`default_nettype wire

FILE: test/tb.sv
// ============================================================================
// tb
// self-checking bench for first_fit_bin_packer_top
// ============================================================================
// Items go in as short packing sets with random sizes under several bin
// capacities. One set fills every bin so the full-row drop case is reached.
// A scoreboard runs its own first-fit placement for every accepted item and
// checks each result in order. The sender works in bursts and the receiver
// stalls on its own pattern.
`timescale 1ns / 100ps

module tb;

    import ffbp_pkg::*;

    localparam int NUM_BINS    = MAX_BINS_DEF;
    localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    class packing_scoreboard;

        typedef struct packed {
            logic [BIN_INDEX_W-1:0] bin_index;
            logic [BINS_USED_W-1:0] bins_used;
            logic                   no_room;
        } placement_t;

        logic [SIZE_W-1:0] bin_fill [MAX_BINS_DEF];
        int unsigned       open_count;
        logic [SIZE_W-1:0] capacity;
        placement_t        placements_due [$];
        int                mismatch_count;

        function new();
            open_count     = 0;
            capacity       = CAP_RESET;
            mismatch_count = 0;
        endfunction

        function void set_capacity(logic [SIZE_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return placements_due.size();
        endfunction

        // first-fit placement of one accepted item
        function void note_item(logic [SIZE_W-1:0] size, logic first);
            logic [SIZE_W:0] total;
            int unsigned     chosen;
            bit              placed;
            placement_t      want;
            chosen = 0;
            placed = 1'b0;
            if (first)
                open_count = 0;
            for (int k = 0; k < open_count; k++)
            begin
                total = {1'b0, bin_fill[k]} + {1'b0, size};
                if (total <= {1'b0, capacity})
                begin
                    bin_fill[k] = total[SIZE_W-1:0];
                    chosen      = k;
                    placed      = 1'b1;
                    break;
                end
            end
            if (!placed && open_count < MAX_BINS_DEF && size <= capacity)
            begin
                chosen           = open_count;
                bin_fill[chosen] = size;
                open_count++;
                placed           = 1'b1;
            end
            want.bin_index = placed ? chosen[BIN_INDEX_W-1:0] : '0;
            want.bins_used = open_count[BINS_USED_W-1:0];
            want.no_room   = !placed;
            placements_due = {placements_due, want};
        endfunction

        task report(string what);
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_placement(logic [23:0] data, logic [0:0] user);
            placement_t             want;
            logic [BIN_INDEX_W-1:0] got_bin;
            logic [BINS_USED_W-1:0] got_used;
            got_bin  = data[BIN_INDEX_W-1:0];
            got_used = data[BIN_INDEX_W +: BINS_USED_W];
            if (placements_due.size() == 0)
            begin
                report($sformatf("unexpected result: bin %0d used %0d no_room %0b",
                                 got_bin, got_used, user[0]));
                return;
            end
            want = placements_due.pop_front();
            if (got_bin !== want.bin_index || got_used !== want.bins_used ||
                user[0] !== want.no_room)
                report($sformatf("got bin %0d used %0d no_room %0b, expected %0d %0d %0b",
                                 got_bin, got_used, user[0],
                                 want.bin_index, want.bins_used, want.no_room));
        endtask

    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;   // [16:0] item_size, rest zero
    logic [0:0]        s_axis_tuser = '0;   // [0] first_item
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // [8:0] bin_index, [18:9] bins_used
    logic [0:0]        m_axis_tuser;        // [0] no_room
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;

    packing_scoreboard sb = new();

    int                cycle_count = 0;
    int                burst_left = 0;
    int                rx_mode = 0;
    int                rx_left = 0;
    logic [SIZE_W-1:0] cur_capacity = CAP_RESET;

    first_fit_bin_packer_top #(
        .MAX_BINS(NUM_BINS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: free-flowing, light and heavy random stalls, or a fixed beat
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(3, 0);
            rx_left <= $urandom_range(200, 16);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(3, 0) != 0);
            2:       m_axis_tready <= ($urandom_range(1, 0) != 0);
            default: m_axis_tready <= ((cycle_count % 8) < 3);
        endcase
    end

    // outputs are stable by the falling edge, ahead of the edge that takes them
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_placement(m_axis_tdata, m_axis_tuser);
    end

    // call right after a rising edge; returns right after one
    task automatic send_item(input logic [SIZE_W-1:0] size, input logic first);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(24 - SIZE_W){1'b0}}, size};
        s_axis_tuser  <= first;
        do
            @(negedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_item(size, first);
        @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
                                                     : $urandom_range(12, 0);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_capacity(value);
        cur_capacity = value;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(int style, int cap);
        int v;
        if ($urandom_range(19, 0) == 0 && cap < SIZE_MAX)
            v = $urandom_range(SIZE_MAX, cap + 1);
        else
        begin
            case (style)
                0:       v = $urandom_range(cap, 0);
                1:       v = $urandom_range(cap / 4, 0);
                2:       v = $urandom_range(cap, cap / 2);
                3:       v = cap - $urandom_range((cap < 16) ? cap : 16, 0);
                default: v = $urandom_range(SIZE_MAX, 0);
            endcase
        end
        return SIZE_W'(v);
    endfunction

    // packing sets led by a first item, with some stray flags and unled sets
    task automatic pack_sets(input int count);
        int sent;
        int set_len;
        int style;
        bit led;
        logic first;
        sent = 0;
        while (sent < count)
        begin
            set_len = $urandom_range(40, 1);
            style   = $urandom_range(4, 0);
            led     = ($urandom_range(7, 0) != 0);
            for (int j = 0; j < set_len && sent < count; j++)
            begin
                first = (j == 0) ? led : ($urandom_range(29, 0) == 0);
                send_item(pick_size(style, cur_capacity), first);
                sent++;
            end
        end
    endtask

    // unit bins: every item opens a bin until the whole row is in use
    task automatic fill_every_bin();
        send_item(17'd1, 1'b1);
        for (int k = 1; k < NUM_BINS; k++)
            send_item(17'd1, 1'b0);
        send_item(17'd1, 1'b0);
        send_item(17'd0, 1'b0);
        send_item(17'd2, 1'b0);
        send_item(SIZE_W'(SIZE_MAX), 1'b0);
        send_item(17'd1, 1'b0);
        send_item(17'd1, 1'b1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset capacity of 1.0
        send_item(17'd0, 1'b0);
        send_item(17'h10000, 1'b0);
        send_item(17'd1, 1'b0);
        send_item(17'h0FFFF, 1'b0);
        send_item(17'h10000, 1'b0);
        send_item(17'h10001, 1'b0);
        send_item(SIZE_W'(SIZE_MAX), 1'b0);
        send_item(17'd0, 1'b0);
        send_item(17'h08000, 1'b1);
        send_item(17'h08000, 1'b0);
        send_item(17'h0AAAA, 1'b0);
        send_item(17'h15555, 1'b0);
        send_item(17'h05556, 1'b0);
        send_item(17'h10000, 1'b1);
        send_item(SIZE_W'(SIZE_MAX), 1'b1);
        send_item(17'd1, 1'b0);

        write_capacity(17'h10000);
        pack_sets(60);
        write_capacity(17'd1);
        fill_every_bin();
        pack_sets(30);
        write_capacity(SIZE_W'(SIZE_MAX));
        pack_sets(40);
        write_capacity(17'd0);
        pack_sets(20);
        repeat (3)
        begin
            write_capacity(SIZE_W'($urandom_range(17'h10000, 1)));
            pack_sets(22);
        end

        wait_idle();
        repeat (NUM_BINS + 16) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
